>>> rtl/wgf_pkg.sv
// ---------------------------------------------------------------------------
// Worker grid factorizer package
// Shared constants and the lane status type.
// ---------------------------------------------------------------------------
package wgf_pkg;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int WORKER_BITS_DEF = 16;
    localparam int EXTENT_BITS_DEF = 32;
    localparam int FIELD_DIMS      = 4;
    localparam int GRID_BITS       = 16;
    localparam int FIRST_TRIAL     = 2;

    // Status that a lane hands to the top-level controller.
    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

>>> rtl/wgf_divider.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle, with remainder.
// ---------------------------------------------------------------------------
module wgf_divider #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = '0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = CW'(W);
            q_next   = num;
            r_next   = '0;
            d_next   = den;
        end
        else if (run_reg)
        begin
            trial = {r_reg[W-1:0], q_reg[W-1]};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg[W-1:0];

endmodule

>>> rtl/wgf_lane.sv
// ---------------------------------------------------------------------------
// Span lane
// Computes ceil(extent / grid) for one dimension with its own divider; a zero extent counts as one.
// ---------------------------------------------------------------------------
module wgf_lane #(
    parameter int EXTENT_BITS = wgf_pkg::EXTENT_BITS_DEF,
    parameter int GRID_W      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [EXTENT_BITS-1:0] extent,
    input  logic [GRID_W-1:0]      grid,
    output wgf_pkg::lane_stat_t    stat,
    output logic [EXTENT_BITS:0]   span
);

    logic [EXTENT_BITS-1:0] e_eff, g_eff, quo, rem;
    logic                   done, busy_reg;

    assign e_eff = (extent == '0) ? EXTENT_BITS'(1) : extent;
    // Grid values never exceed the worker count; widths above the extent
    // field are clipped, which still yields a span of one there.
    always_comb
    begin
        if (GRID_W > EXTENT_BITS && (grid >> EXTENT_BITS) != '0)
            g_eff = '1;
        else
            g_eff = EXTENT_BITS'(grid);
    end

    wgf_divider #(.W(EXTENT_BITS)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go),
        .num  (e_eff),
        .den  (g_eff),
        .done (done),
        .quo  (quo),
        .rem  (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (go)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    assign span      = {1'b0, quo} + {{EXTENT_BITS{1'b0}}, (rem != '0)};
    assign stat.busy = busy_reg;
    assign stat.done = done;

endmodule

>>> rtl/worker_grid_factorizer_top.sv
// ---------------------------------------------------------------------------
// Worker grid factorizer
// Splits a worker count into per-dimension grid factors.
// ---------------------------------------------------------------------------
// The time an item takes depends on the worker count (longest for a large
// prime count): the prime factors are found by trial division on a single
// one-bit-per-cycle divider, and then for each prime all lanes compute their
// spans in parallel on their own dividers, after which a merge stage picks
// the widest dimension. busy stays high from start until the one-cycle result
// strobe done; results cannot be stalled.
module worker_grid_factorizer_top #(
    parameter int MAX_DIMS    = wgf_pkg::MAX_DIMS_DEF,
    parameter int WORKER_BITS = wgf_pkg::WORKER_BITS_DEF,
    parameter int EXTENT_BITS = wgf_pkg::EXTENT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] workers,
    input  logic [2:0]  dim_count,
    input  logic [31:0] extent_0,
    input  logic [31:0] extent_1,
    input  logic [31:0] extent_2,
    input  logic [31:0] extent_3,
    output logic        done,
    output logic [15:0] grid_0,
    output logic [15:0] grid_1,
    output logic [15:0] grid_2,
    output logic [15:0] grid_3
);

    localparam int ND   = wgf_pkg::FIELD_DIMS;
    localparam int WB   = WORKER_BITS;
    localparam int PS   = WB;            // primes fit in WORKER_BITS slots
    localparam int PW   = $clog2(PS + 1);
    localparam int IW   = $clog2(PS);
    localparam int DW   = $clog2(ND);
    localparam int LIM  = (MAX_DIMS < ND) ? MAX_DIMS : ND;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRY   = 3'd1;
    localparam logic [2:0] S_TDIV  = 3'd2;
    localparam logic [2:0] S_ASGN  = 3'd3;
    localparam logic [2:0] S_SPAN  = 3'd4;
    localparam logic [2:0] S_MERGE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]             st_reg, st_next;
    logic [WB-1:0]          rest_reg, rest_next;
    logic [WB-1:0]          f_reg, f_next;
    logic [WB-1:0]          primes_reg [PS];
    logic [PW-1:0]          np_reg, np_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [IW-1:0]          k_idx;
    logic [2:0]             dims_reg, dims_next;
    logic [WB-1:0]          grid_reg [ND];
    logic [EXTENT_BITS-1:0] ext_reg [ND];
    logic                   push;
    logic [WB-1:0]          push_val;
    logic                   done_reg;
    logic [ND-1:0][WB-1:0]  grid_nx;

    logic [2:0]             dc_sat;
    logic [WB-1:0]          w_in;
    logic [2*WB-1:0]        f_sq;

    logic                   dv_go, dv_done;
    logic [WB-1:0]          dv_q, dv_r;

    logic                   ln_go;
    wgf_pkg::lane_stat_t    ln_stat [ND];
    logic [EXTENT_BITS:0]   ln_span [ND];

    logic [DW-1:0]          best;
    logic [EXTENT_BITS:0]   best_span;
    logic [2*WB-1:0]        prod;

    assign w_in   = WB'({16'd0, workers} & ((33'd1 << WB) - 33'd1));
    assign dc_sat = (dim_count > 3'(LIM)) ? 3'(LIM) : dim_count;
    assign f_sq   = f_reg * f_reg;

    wgf_divider #(.W(WB)) u_tdiv (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (dv_go),
        .num  (rest_reg),
        .den  (f_reg),
        .done (dv_done),
        .quo  (dv_q),
        .rem  (dv_r)
    );

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++)
        begin : g_lane
            wgf_lane #(.EXTENT_BITS(EXTENT_BITS), .GRID_W(WB)) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .go    (ln_go),
                .extent(ext_reg[gi]),
                .grid  (grid_reg[gi]),
                .stat  (ln_stat[gi]),
                .span  (ln_span[gi])
            );
        end
    endgenerate

    // Merge: strict greater keeps the lowest dimension on a tie.
    always_comb
    begin
        best      = '0;
        best_span = ln_span[0];
        for (int i = 1; i < ND; i++)
        begin
            if (3'(i) < dims_reg && ln_span[i] > best_span)
            begin
                best      = DW'(i);
                best_span = ln_span[i];
            end
        end
    end

    assign k_idx = IW'(k_reg - 1'b1);
    assign prod  = grid_reg[best] * primes_reg[k_idx];

    always_comb
    begin
        st_next   = st_reg;
        rest_next = rest_reg;
        f_next    = f_reg;
        np_next   = np_reg;
        k_next    = k_reg;
        dims_next = dims_reg;
        dv_go     = 1'b0;
        ln_go     = 1'b0;
        push      = 1'b0;
        push_val  = rest_reg;
        for (int i = 0; i < ND; i++)
            grid_nx[i] = grid_reg[i];
        case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rest_next = w_in;
                    f_next    = WB'(wgf_pkg::FIRST_TRIAL);
                    np_next   = '0;
                    dims_next = dc_sat;
                    for (int i = 0; i < ND; i++)
                        grid_nx[i] = WB'(1);
                    if (w_in > WB'(1) && dc_sat != 3'd0)
                        st_next = S_TRY;
                    else
                        st_next = S_OUT;
                end
            end
            S_TRY:
            begin
                if (f_sq <= {{WB{1'b0}}, rest_reg})
                begin
                    dv_go   = 1'b1;
                    st_next = S_TDIV;
                end
                else
                begin
                    if (rest_reg > WB'(1))
                    begin
                        push    = 1'b1;
                        np_next = np_reg + 1'b1;
                        k_next  = np_reg + 1'b1;
                    end
                    else
                        k_next = np_reg;
                    st_next = S_ASGN;
                end
            end
            S_TDIV:
            begin
                if (dv_done)
                begin
                    if (dv_r == '0)
                    begin
                        push_val  = f_reg;
                        push      = 1'b1;
                        np_next   = np_reg + 1'b1;
                        rest_next = dv_q;
                    end
                    else
                        f_next = f_reg + 1'b1;
                    st_next = S_TRY;
                end
            end
            S_ASGN:
            begin
                if (k_reg == '0)
                    st_next = S_OUT;
                else
                begin
                    ln_go   = 1'b1;
                    st_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (ln_stat[0].done)
                    st_next = S_MERGE;
            end
            S_MERGE:
            begin
                grid_nx[best] = prod[WB-1:0];
                k_next        = k_reg - 1'b1;
                st_next       = S_ASGN;
            end
            S_OUT:
                st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == S_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        f_reg    <= f_next;
        np_reg   <= np_next;
        k_reg    <= k_next;
        dims_reg <= dims_next;
        if (push)
            primes_reg[np_reg[$clog2(PS)-1:0]] <= push_val;
        for (int i = 0; i < ND; i++)
            grid_reg[i] <= grid_nx[i];
        if (st_reg == S_IDLE && start)
        begin
            ext_reg[0] <= EXTENT_BITS'(extent_0);
            ext_reg[1] <= EXTENT_BITS'(extent_1);
            ext_reg[2] <= EXTENT_BITS'(extent_2);
            ext_reg[3] <= EXTENT_BITS'(extent_3);
        end
    end

    assign busy   = (st_reg != S_IDLE);
    assign done   = done_reg;
    assign grid_0 = 16'(grid_reg[0]);
    assign grid_1 = 16'(grid_reg[1]);
    assign grid_2 = 16'(grid_reg[2]);
    assign grid_3 = 16'(grid_reg[3]);

    // Lanes run in lockstep, so all finish together.
    assert property (@(posedge clk) disable iff (!rst_n)
        ln_stat[0].done |-> ln_stat[ND-1].done)
        else $error("lanes out of step");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_MERGE) |-> (k_reg != '0))
        else $error("merge with no prime left");
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("start not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SPAN) |-> ln_stat[0].busy)
        else $error("lane idle while spans are pending");

endmodule
